@@ design/buddy_block_allocator_top_macros.svh @@
// Assertion macros used by the checker file of the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bba_pkg.sv @@
`timescale 1ns / 1ps

package bba_pkg;

    localparam int TOP_BLOCKS = 16;
    localparam int TREE_DEPTH = 4;
    localparam int LEAF_BYTES = 4096;

    localparam int LEAF_SHIFT = $clog2(LEAF_BYTES);
    localparam int TOP_BYTES  = LEAF_BYTES << TREE_DEPTH;

    // Field widths of the request and response words.
    localparam int SIZE_W   = 20;
    localparam int OFFSET_W = 8;
    localparam int NODE_W   = 5;
    localparam int LEAVES_W = 5;

    // Free map bits are indexed directly by node number; bit 0 is never set.
    localparam int MAP_W     = 2 ** NODE_W;
    localparam int LAST_NODE = (2 << TREE_DEPTH) - 1;
    localparam int TOP_W     = (TOP_BLOCKS > 1) ? $clog2(TOP_BLOCKS) : 1;
    localparam int DEPTH_W   = $clog2(TREE_DEPTH + 1);
    localparam int NEED_W    = SIZE_W + 1 - LEAF_SHIFT;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_FREE   = 2'd1,
        STATUS_MALFORMED = 2'd2
    } status_t;

    typedef struct packed {
        op_t                 operation;
        logic [SIZE_W-1:0]   request_size;
        logic [OFFSET_W-1:0] block_offset;
        logic [NODE_W-1:0]   block_node;
    } bba_req_t;

    typedef struct packed {
        status_t             status;
        logic [OFFSET_W-1:0] granted_offset;
        logic [NODE_W-1:0]   granted_node;
        logic [LEAVES_W-1:0] granted_leaves;
    } bba_rsp_t;

endpackage

@@ design/bba_req_if.sv @@
`timescale 1ns / 1ps

interface bba_req_if;
    import bba_pkg::*;

    logic     valid;
    logic     ready;
    bba_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ design/bba_rsp_if.sv @@
`timescale 1ns / 1ps

interface bba_rsp_if;
    import bba_pkg::*;

    logic     valid;
    logic     ready;
    bba_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ design/buddy_block_allocator_top.sv @@
`timescale 1ns / 1ps

// Buddy block allocator over sixteen top blocks, each a binary tree of sixteen leaves, four levels deep.
// The req channel carries one request word: an allocation of request_size bytes, or a
// free of the block given by block_offset and block_node. The rsp channel returns one
// word per request with a status and, for a granted allocation, the block's offset,
// node number and size in leaves. Both channels use a valid/ready handshake.
// The block takes one request at a time; req.ready is high only while it is idle.
// An allocation sweeps the free maps of all top blocks, one top block per cycle, then
// chooses a block, claims its node and splits it down to the size asked for, freeing
// each right half; when no block is free it answers right after the choice. A free
// checks the map, then merges one level per cycle with free buddies. A malformed
// allocation answers straight from acceptance and a malformed free after the map
// check. The next request is accepted in the cycle after the response word is loaded.
// The response sits in an output register, so a new request is accepted while the last
// response still waits; if the receiver stalls the next one, the sequencer holds its
// finished result and takes no further request until the register drains.
// Reset (rst_n low, asynchronous) marks only the root of every top block as free and
// clears the response valid flag; there is no clearing pass.
module buddy_block_allocator_top (
    input logic       clk,
    input logic       rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);
    import bba_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_TAKE   = 8'b0000_1000,
        S_SPLIT  = 8'b0001_0000,
        S_CHECK  = 8'b0010_0000,
        S_MERGE  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    // Depth of a node: index of its leading one.
    function automatic logic [DEPTH_W-1:0] depth_of(input logic [NODE_W-1:0] n);
        logic [DEPTH_W-1:0] d;
        d = '0;
        for (int i = 1; i < NODE_W; i++) begin
            if (n[i]) begin
                d = DEPTH_W'(i);
            end
        end
        return d;
    endfunction

    // Leaf position of a node inside its top block.
    function automatic logic [TREE_DEPTH-1:0] node_pos(input logic [NODE_W-1:0] n);
        logic [DEPTH_W-1:0] d;
        logic [NODE_W-1:0]  rel;
        logic [NODE_W-1:0]  shifted;
        d       = depth_of(n);
        rel     = n & ~(NODE_W'(1) << d);
        shifted = rel << (DEPTH_W'(TREE_DEPTH) - d);
        return shifted[TREE_DEPTH-1:0];
    endfunction

    // All nodes at depth d.
    function automatic logic [MAP_W-1:0] level_mask(input logic [DEPTH_W-1:0] d);
        logic [MAP_W-1:0] m;
        for (int i = 0; i < MAP_W; i++) begin
            m[i] = (i >= (1 << d)) && (i < (2 << d));
        end
        return m;
    endfunction

    // All nodes above depth d, that is, larger than a depth-d node.
    function automatic logic [MAP_W-1:0] upper_mask(input logic [DEPTH_W-1:0] d);
        logic [MAP_W-1:0] m;
        for (int i = 0; i < MAP_W; i++) begin
            m[i] = (i >= 1) && (i < (1 << d));
        end
        return m;
    endfunction

    // Nodes that are an ancestor of, a descendant of, or equal to the given node.
    function automatic logic [MAP_W-1:0] overlap_mask(input logic [NODE_W-1:0] n);
        logic [MAP_W-1:0]   m;
        logic [DEPTH_W-1:0] dn;
        logic [DEPTH_W-1:0] dm;
        m  = '0;
        dn = depth_of(n);
        for (int i = 1; i <= LAST_NODE; i++) begin
            dm = depth_of(NODE_W'(i));
            if (dm <= dn) begin
                m[i] = ((n >> (dn - dm)) == NODE_W'(i));
            end else begin
                m[i] = ((NODE_W'(i) >> (dm - dn)) == n);
            end
        end
        return m;
    endfunction

    function automatic logic [NODE_W-1:0] lowest_set(input logic [MAP_W-1:0] v);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = NODE_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [NODE_W-1:0] highest_set(input logic [MAP_W-1:0] v);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAP_W; i++) begin
            if (v[i]) begin
                idx = NODE_W'(i);
            end
        end
        return idx;
    endfunction

    // Sequencer and working registers.
    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    status_t              status_reg, status_next;
    logic [TOP_W-1:0]     top_cnt_reg, top_cnt_next;
    logic [TOP_W-1:0]     work_top_reg, work_top_next;
    logic [NODE_W-1:0]    cur_node_reg, cur_node_next;
    logic [DEPTH_W-1:0]   cur_depth_reg, cur_depth_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [LEAVES_W-1:0]  leaves_reg, leaves_next;
    logic [OFFSET_W-1:0]  off_reg, off_next;
    logic                 exact_hit_reg, exact_hit_next;
    logic [NODE_W-1:0]    exact_node_reg, exact_node_next;
    logic [TOP_W-1:0]     exact_top_reg, exact_top_next;
    logic                 split_hit_reg, split_hit_next;
    logic [NODE_W-1:0]    split_node_reg, split_node_next;
    logic [TOP_W-1:0]     split_top_reg, split_top_next;
    logic                 out_valid_reg, out_valid_next;
    bba_rsp_t             out_word_reg, out_word_next;

    // Free maps, one word per top block, with one read address and one write address.
    logic [MAP_W-1:0]     map_reg [TOP_BLOCKS];
    logic [TOP_W-1:0]     rd_top;
    logic [MAP_W-1:0]     rd_word;
    logic                 map_we;
    logic [MAP_W-1:0]     map_wdata;

    // Request decode.
    logic                 req_fire;
    logic                 size_bad;
    logic [SIZE_W:0]      size_sum;
    logic [NEED_W-1:0]    need;
    logic [DEPTH_W-1:0]   k_val;

    // Shared search unit outputs.
    logic [MAP_W-1:0]     lvl_vec;
    logic [MAP_W-1:0]     up_vec;
    logic [NODE_W-1:0]    lvl_node;
    logic [NODE_W-1:0]    up_node;

    logic                 check_bad;
    logic [NODE_W-1:0]    buddy;
    logic                 out_free;

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_word_reg;

    assign req_fire = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign rd_top  = (state_reg == S_SCAN) ? top_cnt_reg : work_top_reg;
    assign rd_word = map_reg[rd_top];

    // Round the size up to whole leaves, then to a power of two: k counts the
    // powers of two below the leaf count.
    assign size_bad = (req.payload.request_size == '0)
                   || (32'(req.payload.request_size) > 32'(TOP_BYTES));
    assign size_sum = (SIZE_W + 1)'(req.payload.request_size) + (SIZE_W + 1)'(LEAF_BYTES - 1);
    assign need     = NEED_W'(size_sum >> LEAF_SHIFT);

    always_comb
    begin
        k_val = '0;
        for (int i = 0; i < TREE_DEPTH; i++) begin
            if (32'(need) > (32'd1 << i)) begin
                k_val = k_val + 1'b1;
            end
        end
    end

    assign lvl_vec  = rd_word & level_mask(depth_reg);
    assign up_vec   = rd_word & upper_mask(depth_reg);
    assign lvl_node = lowest_set(lvl_vec);
    assign up_node  = highest_set(up_vec);

    assign buddy = cur_node_reg ^ NODE_W'(1);

    assign check_bad = (cur_node_reg == '0)
                    || (32'(cur_node_reg) > 32'(LAST_NODE))
                    || (32'(off_reg >> TREE_DEPTH) >= 32'(TOP_BLOCKS))
                    || (node_pos(cur_node_reg) != off_reg[TREE_DEPTH-1:0])
                    || (|(rd_word & overlap_mask(cur_node_reg)));

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        top_cnt_next    = top_cnt_reg;
        work_top_next   = work_top_reg;
        cur_node_next   = cur_node_reg;
        cur_depth_next  = cur_depth_reg;
        depth_next      = depth_reg;
        leaves_next     = leaves_reg;
        off_next        = off_reg;
        exact_hit_next  = exact_hit_reg;
        exact_node_next = exact_node_reg;
        exact_top_next  = exact_top_reg;
        split_hit_next  = split_hit_reg;
        split_node_next = split_node_reg;
        split_top_next  = split_top_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_word_next   = out_word_reg;
        map_we          = 1'b0;
        map_wdata       = rd_word;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire) begin
                    op_next        = req.payload.operation;
                    cur_node_next  = req.payload.block_node;
                    off_next       = req.payload.block_offset;
                    work_top_next  = TOP_W'(req.payload.block_offset >> TREE_DEPTH);
                    depth_next     = DEPTH_W'(TREE_DEPTH) - k_val;
                    leaves_next    = LEAVES_W'(1) << k_val;
                    top_cnt_next   = '0;
                    exact_hit_next = 1'b0;
                    split_hit_next = 1'b0;
                    if (req.payload.operation == OP_FREE) begin
                        state_next = S_CHECK;
                    end else if (size_bad) begin
                        status_next = STATUS_MALFORMED;
                        state_next  = S_FINISH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            // Exact fit: lowest node number wins, then lowest top block.
            // Split source: highest node number above the target depth wins.
            S_SCAN:
            begin
                if ((|lvl_vec) && (!exact_hit_reg || lvl_node < exact_node_reg)) begin
                    exact_hit_next  = 1'b1;
                    exact_node_next = lvl_node;
                    exact_top_next  = top_cnt_reg;
                end
                if ((|up_vec) && (!split_hit_reg || up_node > split_node_reg)) begin
                    split_hit_next  = 1'b1;
                    split_node_next = up_node;
                    split_top_next  = top_cnt_reg;
                end
                if (32'(top_cnt_reg) == 32'(TOP_BLOCKS - 1)) begin
                    state_next = S_DECIDE;
                end else begin
                    top_cnt_next = top_cnt_reg + 1'b1;
                end
            end

            S_DECIDE:
            begin
                if (exact_hit_reg) begin
                    work_top_next  = exact_top_reg;
                    cur_node_next  = exact_node_reg;
                    cur_depth_next = depth_reg;
                    state_next     = S_TAKE;
                end else if (split_hit_reg) begin
                    work_top_next  = split_top_reg;
                    cur_node_next  = split_node_reg;
                    cur_depth_next = depth_of(split_node_reg);
                    state_next     = S_TAKE;
                end else begin
                    status_next = STATUS_NO_FREE;
                    state_next  = S_FINISH;
                end
            end

            S_TAKE:
            begin
                map_we     = 1'b1;
                map_wdata  = rd_word & ~(MAP_W'(1) << cur_node_reg);
                state_next = S_SPLIT;
            end

            // Walk down the left path, freeing each right half on the way.
            S_SPLIT:
            begin
                if (cur_depth_reg < depth_reg) begin
                    map_we         = 1'b1;
                    map_wdata      = rd_word
                                   | (MAP_W'(1) << {cur_node_reg[NODE_W-2:0], 1'b1});
                    cur_node_next  = {cur_node_reg[NODE_W-2:0], 1'b0};
                    cur_depth_next = cur_depth_reg + 1'b1;
                end else begin
                    status_next = STATUS_OK;
                    state_next  = S_FINISH;
                end
            end

            S_CHECK:
            begin
                if (check_bad) begin
                    status_next = STATUS_MALFORMED;
                    state_next  = S_FINISH;
                end else begin
                    state_next = S_MERGE;
                end
            end

            // Absorb a free buddy and move up one level per cycle.
            S_MERGE:
            begin
                map_we = 1'b1;
                if ((cur_node_reg > NODE_W'(1)) && rd_word[buddy]) begin
                    map_wdata     = rd_word & ~(MAP_W'(1) << buddy);
                    cur_node_next = cur_node_reg >> 1;
                end else begin
                    map_wdata   = rd_word | (MAP_W'(1) << cur_node_reg);
                    status_next = STATUS_OK;
                    state_next  = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free) begin
                    out_valid_next       = 1'b1;
                    out_word_next.status = status_reg;
                    if (op_reg == OP_ALLOC && status_reg == STATUS_OK) begin
                        out_word_next.granted_offset = (OFFSET_W'(work_top_reg) << TREE_DEPTH)
                                                     | OFFSET_W'(node_pos(cur_node_reg));
                        out_word_next.granted_node   = cur_node_reg;
                        out_word_next.granted_leaves = leaves_reg;
                    end else begin
                        out_word_next.granted_offset = '0;
                        out_word_next.granted_node   = '0;
                        out_word_next.granted_leaves = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            top_cnt_reg   <= '0;
            exact_hit_reg <= 1'b0;
            split_hit_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            top_cnt_reg   <= top_cnt_next;
            exact_hit_reg <= exact_hit_next;
            split_hit_reg <= split_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        status_reg     <= status_next;
        work_top_reg   <= work_top_next;
        cur_node_reg   <= cur_node_next;
        cur_depth_reg  <= cur_depth_next;
        depth_reg      <= depth_next;
        leaves_reg     <= leaves_next;
        off_reg        <= off_next;
        exact_node_reg <= exact_node_next;
        exact_top_reg  <= exact_top_next;
        split_node_reg <= split_node_next;
        split_top_reg  <= split_top_next;
        out_word_reg   <= out_word_next;
    end

    // Reset leaves only the root of every top block free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int t = 0; t < TOP_BLOCKS; t++) begin
                map_reg[t] <= MAP_W'(2);
            end
        end else if (map_we) begin
            map_reg[work_top_reg] <= map_wdata;
        end
    end

endmodule

@@ design/bba_checker.sv @@
`timescale 1ns / 1ps
`include "buddy_block_allocator_top_macros.svh"

module bba_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input bba_pkg::bba_rsp_t rsp_payload
);
    import bba_pkg::*;

    // A stalled response word stays put.
    `BBA_ASSERT_NEXT(a_rsp_hold, clk, rst_n,
        rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload),
        "response word changed while stalled")

    // Only one request is in work at a time.
    `BBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        req_valid && req_ready, !req_ready,
        "request accepted while busy")

    // No request is answered in the cycle right after acceptance.
    `BBA_ASSERT_NEXT(a_no_instant_rsp, clk, rst_n,
        req_valid && req_ready, !$rose(rsp_valid),
        "response appeared too early")

    // A new response only comes out of a busy sequencer.
    `BBA_ASSERT_IMPLY(a_rsp_from_busy, clk, rst_n,
        $rose(rsp_valid), !$past(req_ready),
        "response without work in progress")

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
